@@ src/sorted_table_binary_search_macros.svh @@
// assertion macros for the sorted table binary search checker
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// checked only outside reset
`define STBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset too
`define STBS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/stbs_pkg.sv @@
// shared codes, widths and control types of the sorted table binary search
package stbs_pkg;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_FIRST = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_LAST  = 1'b1;

   localparam int FIRST_W     = 4;
   localparam int LAST_W      = 5;
   localparam int INDEX_W     = 4;
   localparam int BOUND_W     = 6;
   localparam int RSP_TDATA_W = 8;

   localparam logic [LAST_W-1:0] SEARCH_LAST_RESET = 5'd15;

   typedef struct packed {
      logic mem_wr;
      logic start;
      logic probe;
      logic hit;
      logic step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic start_empty;
      logic match;
      logic next_empty;
   } status_type;

endpackage

@@ src/stbs_datapath.sv @@
// table memory, search bounds, compare and result registers
module stbs_datapath #(
   parameter int TABLE_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  stbs_pkg::cmd_type                      cmd,
   output stbs_pkg::status_type                   status,
   input  logic                                   csr_we,
   input  logic [stbs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [stbs_pkg::INDEX_W-1:0]           entry_index,
   input  logic signed [VALUE_WIDTH-1:0]          item_value,
   output logic                                   rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]           rsp_position
);

   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int XW     = (AW > stbs_pkg::INDEX_W) ? AW : stbs_pkg::INDEX_W;
   localparam int HI_CAP = (TABLE_DEPTH - 1 < 15) ? TABLE_DEPTH - 1 : 15;

   logic [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];

   logic [stbs_pkg::FIRST_W-1:0] search_first_ff;
   logic [stbs_pkg::LAST_W-1:0]  search_last_ff;

   logic signed [stbs_pkg::BOUND_W-1:0] lo_ff, lo_in;
   logic signed [stbs_pkg::BOUND_W-1:0] hi_ff, hi_in;
   logic signed [VALUE_WIDTH-1:0]       key_ff;
   logic signed [VALUE_WIDTH-1:0]       rd_data_ff;
   logic [stbs_pkg::INDEX_W-1:0]        mid_ff;
   logic                                found_ff;
   logic [stbs_pkg::INDEX_W-1:0]        pos_ff;
   logic                                rsp_found_ff;
   logic [stbs_pkg::INDEX_W-1:0]        rsp_position_ff;

   logic signed [stbs_pkg::BOUND_W-1:0] lo_init, hi_init, hi_cap, hi_sat;
   logic signed [stbs_pkg::BOUND_W-1:0] mid_s, step_lo, step_hi;
   logic [stbs_pkg::BOUND_W-1:0]        span, mid_calc;
   logic [XW-1:0]                       wr_addr_x, rd_addr_x;
   logic                                idx_ok;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         search_first_ff <= '0;
         search_last_ff  <= stbs_pkg::SEARCH_LAST_RESET;
      end else if (csr_we) begin
         if (csr_index == stbs_pkg::CSR_SEARCH_FIRST) begin
            search_first_ff <= csr_wdata[stbs_pkg::FIRST_W-1:0];
         end
         if (csr_index == stbs_pkg::CSR_SEARCH_LAST) begin
            search_last_ff <= csr_wdata[stbs_pkg::LAST_W-1:0];
         end
      end
   end

   // initial bounds, last index capped to the table
   always_comb begin
      lo_init = {2'b00, search_first_ff};
      hi_init = {search_last_ff[stbs_pkg::LAST_W-1], search_last_ff};
      hi_cap  = stbs_pkg::BOUND_W'(HI_CAP);
      hi_sat  = (hi_init > hi_cap) ? hi_cap : hi_init;
   end

   // probe point from the current bounds
   always_comb begin
      span     = stbs_pkg::BOUND_W'(hi_ff - lo_ff);
      mid_calc = stbs_pkg::BOUND_W'(lo_ff) + {1'b0, span[stbs_pkg::BOUND_W-1:1]};
      mid_s    = {2'b00, mid_ff};
      step_lo  = mid_s + 6'sd1;
      step_hi  = mid_s - 6'sd1;
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start) begin
         lo_in = lo_init;
         hi_in = hi_sat;
      end else if (cmd.step) begin
         if (rd_data_ff > key_ff) begin
            hi_in = step_hi;
         end else begin
            lo_in = step_lo;
         end
      end
   end

   always_comb begin
      status.start_empty = lo_init > hi_sat;
      status.match       = rd_data_ff == key_ff;
      status.next_empty  = (rd_data_ff > key_ff) ? (lo_ff > step_hi) : (step_lo > hi_ff);
   end

   assign wr_addr_x = XW'(entry_index);
   assign rd_addr_x = XW'(mid_calc[stbs_pkg::INDEX_W-1:0]);
   assign idx_ok    = {{(32 - stbs_pkg::INDEX_W){1'b0}}, entry_index} < 32'(TABLE_DEPTH);

   // table memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_wr && idx_ok) begin
         table_mem[wr_addr_x[AW-1:0]] <= item_value;
      end
      if (cmd.probe) begin
         rd_data_ff <= table_mem[rd_addr_x[AW-1:0]];
         mid_ff     <= mid_calc[stbs_pkg::INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.start) begin
         key_ff   <= item_value;
         found_ff <= 1'b0;
         pos_ff   <= '0;
      end else if (cmd.hit) begin
         found_ff <= 1'b1;
         pos_ff   <= mid_ff;
      end
      if (cmd.load_rsp) begin
         rsp_found_ff    <= found_ff;
         rsp_position_ff <= pos_ff;
      end
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

@@ src/stbs_ctrl.sv @@
// controller state machine for writes, probes and result hand-off
module stbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_opcode,
   input  logic                 rsp_tready,
   input  stbs_pkg::status_type status,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   output stbs_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_PROBE   = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;
   localparam logic [1:0] ST_REPORT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_opcode == stbs_pkg::OP_WRITE) begin
                  cmd.mem_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.start_empty ? ST_REPORT : ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            state_in  = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = ST_REPORT;
            end else begin
               cmd.step = 1'b1;
               state_in = status.next_empty ? ST_REPORT : ST_PROBE;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ src/sorted_table_binary_search.sv @@
// Sorted table binary search: top level joining controller and datapath.
// A write item stores item_value at entry_index and gives no result. A search
// item runs a binary search over [search_first, search_last] and gives one result: it is
// accepted, then each probe is a registered read of the table memory and a compare that
// moves a bound or stops on a match, then the result goes to the output register once
// that register is free; an empty range goes straight from accept to the result. One
// item is in work at a time; a result waiting in the output register does not stop the
// next item from being accepted.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // opcode
   input  logic                                  req_tuser,
   // entry_index, item_value, zero fill
   input  logic [((stbs_pkg::INDEX_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // found
   output logic                                  rsp_tuser,
   // position, zero fill
   output logic [stbs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [stbs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   stbs_pkg::cmd_type    cmd;
   stbs_pkg::status_type status;

   logic [stbs_pkg::INDEX_W-1:0]  entry_index;
   logic signed [VALUE_WIDTH-1:0] item_value;
   logic [stbs_pkg::INDEX_W-1:0]  rsp_position;

   assign entry_index = req_tdata[stbs_pkg::INDEX_W-1:0];
   assign item_value  = req_tdata[stbs_pkg::INDEX_W +: VALUE_WIDTH];
   assign rsp_tdata   = {{(stbs_pkg::RSP_TDATA_W - stbs_pkg::INDEX_W){1'b0}}, rsp_position};

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .entry_index  (entry_index),
      .item_value   (item_value),
      .rsp_found    (rsp_tuser),
      .rsp_position (rsp_position)
   );

endmodule

@@ src/stbs_checker.sv @@
// port-level assertions for the sorted table binary search, bound to the top level
`include "sorted_table_binary_search_macros.svh"

module stbs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic                             rsp_tuser,
   input logic [stbs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   `STBS_ASSERT_RST(a_no_rsp_after_reset, reset |=> !rsp_tvalid, "result valid right after reset")

   `STBS_ASSERT(a_miss_pos_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "miss with nonzero position")

   `STBS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   `STBS_ASSERT(a_write_no_rsp, req_tvalid && req_tready && req_tuser == stbs_pkg::OP_WRITE && !rsp_tvalid |=> !rsp_tvalid, "write item gave a result")

   `STBS_ASSERT(a_search_busy, req_tvalid && req_tready && req_tuser == stbs_pkg::OP_SEARCH |=> !req_tready, "new item taken during a search")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

@@ verif/bsearch_checker.sv @@
// checker for the sorted table binary search: mirrors the table and range, predicts and compares
module bsearch_checker
   import stbs_pkg::*;
#(
   parameter int DEPTH   = 16,
   parameter int VALUE_W = 32,
   parameter int REQ_W   = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // opcode
   input  logic                   req_tuser,
   // entry_index, item_value, zero fill
   input  logic [REQ_W-1:0]       req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // found
   input  logic                   rsp_tuser,
   // position, zero fill
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] position;
   } lookup_type;

   logic signed [VALUE_W-1:0] entry_mirror [DEPTH];
   logic [FIRST_W-1:0]        range_first;
   logic [LAST_W-1:0]         range_last;
   lookup_type                lookup_q [$];
   int                        mismatches = 0;
   int                        waiting = 0;

   assign fail_count    = mismatches;
   assign pending_count = waiting;

   function automatic lookup_type search_table(input logic signed [VALUE_W-1:0] key);
      int         lo;
      int         hi;
      int         mid;
      lookup_type hit;
      hit = '0;
      lo  = int'(range_first);
      hi  = int'($signed(range_last));
      if (hi > DEPTH - 1) hi = DEPTH - 1;
      while (lo <= hi && !hit.found) begin
         mid = lo + (hi - lo) / 2;
         if (entry_mirror[mid] == key) begin
            hit.found    = 1'b1;
            hit.position = mid[INDEX_W-1:0];
         end else if (entry_mirror[mid] > key) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin : watch
      lookup_type got;
      lookup_type want;
      if (reset) begin
         range_first = '0;
         range_last  = SEARCH_LAST_RESET;
         lookup_q.delete();
         waiting = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEARCH_FIRST: range_first = csr_wdata[FIRST_W-1:0];
               CSR_SEARCH_LAST:  range_last  = csr_wdata[LAST_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found    = rsp_tuser;
            got.position = rsp_tdata[INDEX_W-1:0];
            if (lookup_q.size() == 0) begin
               $error("result with no search pending: found %0d position %0d",
                      got.found, got.position);
               mismatches++;
            end else begin
               want = lookup_q.pop_front();
               if (got.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, got.found);
                  mismatches++;
               end
               if (got.position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position, got.position);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE) begin
               entry_mirror[req_tdata[INDEX_W-1:0]] = req_tdata[INDEX_W +: VALUE_W];
            end else begin
               lookup_q.push_back(search_table(req_tdata[INDEX_W +: VALUE_W]));
            end
         end
         waiting = lookup_q.size();
      end
   end

endmodule

@@ verif/tb_top.sv @@
// testbench top for the sorted table binary search: clock, reset, stimulus and verdict
module tb_top;
   import stbs_pkg::*;

   localparam int DEPTH         = 16;
   localparam int VALUE_W       = 32;
   localparam int REQ_W         = ((INDEX_W + VALUE_W + 7) / 8) * 8;
   localparam int ITEM_TARGET   = 1800;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [LAST_W-1:0] LAST_EMPTY = 5'h1F;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic                   req_tuser;
   logic [REQ_W-1:0]       req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   rsp_tuser;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending_count;

   int                        items_sent;
   int                        req_gap_max;
   int                        rsp_stall_max;
   logic signed [VALUE_W-1:0] loaded_vals [DEPTH];

   sorted_table_binary_search #(
      .TABLE_DEPTH(DEPTH),
      .VALUE_WIDTH(VALUE_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bsearch_checker #(
      .DEPTH  (DEPTH),
      .VALUE_W(VALUE_W),
      .REQ_W  (REQ_W)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tuser    (rsp_tuser),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // result side back-pressure
   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         stall = $urandom_range(rsp_stall_max);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
            @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_item(input logic op, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val);
      int gap;
      gap = $urandom_range(req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_W'({val, idx});
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic store_entry(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
      push_item(OP_WRITE, idx, val);
      loaded_vals[idx] = val;
   endtask

   task automatic find_value(input logic [VALUE_W-1:0] key);
      push_item(OP_SEARCH, INDEX_W'($urandom), key);
   endtask

   task automatic set_range(input logic [FIRST_W-1:0] first, input logic [LAST_W-1:0] last);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SEARCH_FIRST;
      csr_wdata <= CSR_DATA_W'(first);
      @(negedge clock);
      csr_index <= CSR_SEARCH_LAST;
      csr_wdata <= CSR_DATA_W'(last);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic load_random_table();
      logic signed [VALUE_W-1:0] vals [DEPTH];
      logic signed [VALUE_W-1:0] hold;
      logic signed [VALUE_W-1:0] base;
      int                        mode;
      int                        i;
      int                        j;
      int                        idx;
      bit                        downward;
      mode = $urandom_range(3);
      base = $urandom;
      for (i = 0; i < DEPTH; i++) begin
         case (mode)
            1:       vals[i] = int'($urandom_range(7)) - 4;
            2:       vals[i] = base + int'($urandom_range(40));
            default: vals[i] = $urandom;
         endcase
      end
      for (i = 1; i < DEPTH; i++) begin
         hold = vals[i];
         j = i - 1;
         while (j >= 0 && vals[j] > hold) begin
            vals[j + 1] = vals[j];
            j--;
         end
         vals[j + 1] = hold;
      end
      if (mode == 3) begin
         vals[0]         = VALUE_MIN;
         vals[DEPTH - 1] = VALUE_MAX;
      end
      downward = 1'($urandom_range(1));
      for (i = 0; i < DEPTH; i++) begin
         idx = downward ? DEPTH - 1 - i : i;
         store_entry(INDEX_W'(idx), vals[idx]);
      end
   endtask

   function automatic logic [VALUE_W-1:0] pick_key();
      int pick;
      int slot;
      pick = $urandom_range(99);
      slot = $urandom_range(DEPTH - 1);
      if (pick < 50) return loaded_vals[slot];
      if (pick < 70) return loaded_vals[slot] + ((pick % 2) ? 1 : -1);
      if (pick < 85) return $urandom;
      case ($urandom_range(3))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   initial begin : stimulus
      int i;
      int n;
      int first_pick;
      int last_pick;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = OP_WRITE;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_SEARCH_FIRST;
      csr_wdata     = '0;
      items_sent    = 0;
      req_gap_max   = 18;
      rsp_stall_max = 18;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full ascending table with both extremes, then edge searches
      set_range(4'd0, 5'd15);
      for (i = 0; i < DEPTH; i++) begin
         if (i == 0) store_entry(INDEX_W'(i), VALUE_MIN);
         else if (i == DEPTH - 1) store_entry(INDEX_W'(i), VALUE_MAX);
         else store_entry(INDEX_W'(i), VALUE_W'(i * 1000 - 7000));
      end
      find_value(VALUE_MIN);
      find_value(VALUE_MAX);
      find_value(32'sd1000);
      find_value(32'sd1001);
      find_value('1);
      set_range(4'd0, LAST_EMPTY);
      find_value(32'sd1000);
      set_range(4'd15, 5'd15);
      find_value(VALUE_MAX);
      set_range(4'd9, 5'd4);
      find_value(32'sd1000);
      // out of order entry that lies off the probe path
      set_range(4'd0, 5'd15);
      store_entry(4'd8, -32'sd9999999);
      find_value(-32'sd9999999);

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(3))
            0:       req_gap_max = 0;
            1:       req_gap_max = 18;
            2:       req_gap_max = 3;
            default: req_gap_max = $urandom_range(18);
         endcase
         case ($urandom_range(3))
            0:       rsp_stall_max = 0;
            1:       rsp_stall_max = 18;
            2:       rsp_stall_max = 3;
            default: rsp_stall_max = $urandom_range(18);
         endcase
         first_pick = $urandom_range(15);
         if ($urandom_range(3) == 0) begin
            first_pick = $urandom_range(1) ? 15 : 0;
            last_pick  = $urandom_range(1) ? 15 : -1;
         end else if ($urandom_range(4) == 0) begin
            last_pick = int'($urandom_range(16)) - 1;
         end else begin
            last_pick = $urandom_range(15, first_pick);
         end
         set_range(FIRST_W'(first_pick), LAST_W'(last_pick));
         if ($urandom_range(99) < 35) load_random_table();
         n = $urandom_range(60, 20);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8) store_entry(INDEX_W'($urandom), $urandom);
            else find_value(pick_key());
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES + 4) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/stbs_pkg.sv
src/stbs_datapath.sv
src/stbs_ctrl.sv
src/sorted_table_binary_search.sv
src/stbs_checker.sv
verif/bsearch_checker.sv
verif/tb_top.sv
